FILE: rtl/rck_pkg.sv
// Package for the rail condition Kalman speed limit block.
// Holds fixed-point widths, constants, codes, reset values and shared types.
// No dependencies; every other file of the block imports it.
package rck_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int UNC_W      = FRAC_BITS + 4;
  localparam int SPEED_W    = 16;
  localparam int NOISE_W    = 16;
  localparam int SLOPE_W    = 20;
  localparam int TIME_W     = 63;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int NUM_EST    = 4;
  localparam int IDX_W      = 2;

  localparam int MUL_A_W = UNC_W;
  localparam int MUL_B_W = FRAC_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RES_W   = PROD_W - FRAC_BITS;

  localparam int ONE_I = 1 << FRAC_BITS;

  localparam logic [FRAC_W-1:0] ONE        = FRAC_W'(ONE_I);
  localparam logic [FRAC_W-1:0] HALF       = FRAC_W'(ONE_I / 2);
  localparam logic [FRAC_W-1:0] R_FLOOR    = FRAC_W'((ONE_I + 50) / 100);
  localparam logic [FRAC_W-1:0] FRIC_FLOOR = FRAC_W'((ONE_I + 5) / 10);
  localparam logic [UNC_W-1:0]  UNC_MAX    = {UNC_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  localparam logic [FUNC_W-1:0] FUNC_NONE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POWER  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CONG   = 3'd4;

  localparam logic [IDX_W-1:0] EST_TRACK  = 2'd0;
  localparam logic [IDX_W-1:0] EST_POWER  = 2'd1;
  localparam logic [IDX_W-1:0] EST_SIGNAL = 2'd2;
  localparam logic [IDX_W-1:0] EST_CONG   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESIGN_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMAGE_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_FAIL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONG_CAP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONG_SLOPE    = 3'd5;

  localparam logic [NOISE_W-1:0] RST_PROCESS_NOISE = NOISE_W'((3 * ONE_I + 500) / 1000);
  localparam logic [SPEED_W-1:0] RST_DESIGN_SPEED  = SPEED_W'(25600);
  localparam logic [FRAC_W-1:0]  RST_DAMAGE_THRESH = FRAC_W'((3 * ONE_I + 5) / 10);
  localparam logic [FRAC_W-1:0]  RST_SIG_FAIL      = FRAC_W'(ONE_I / 4);
  localparam logic [FRAC_W-1:0]  RST_CONG_CAP      = FRAC_W'((7 * ONE_I + 5) / 10);
  localparam logic [SLOPE_W-1:0] RST_CONG_SLOPE    = SLOPE_W'((5 * ONE_I) / 2);
  localparam logic [FRAC_W-1:0]  RST_CONG_EST      = FRAC_W'((2 * ONE_I + 2) / 5);

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

  function automatic logic [FRAC_W-1:0] clamp_one(input logic [FRAC_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

FILE: rtl/rck_in_if.sv
// Report channel of the rail condition Kalman speed limit block.
// Carries one report item with valid and ready; depends on rck_pkg.
interface rck_in_if;
  import rck_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [FRAC_W-1:0]    reliability;
  logic [FRAC_W-1:0]    severity;
  logic [FRAC_W-1:0]    congestion_value;
  logic                 value_present;
  logic [TIME_W-1:0]    report_time;

  modport source (output valid, func, reliability, severity, congestion_value,
                  value_present, report_time, input ready);
  modport sink (input valid, func, reliability, severity, congestion_value,
                value_present, report_time, output ready);
endinterface

FILE: rtl/rck_out_if.sv
// Result channel of the rail condition Kalman speed limit block.
// Carries the speed limit, the four estimates and the time; depends on rck_pkg.
interface rck_out_if;
  import rck_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SPEED_W-1:0]   speed_limit;
  logic [FRAC_W-1:0]    track_estimate;
  logic [FRAC_W-1:0]    power_estimate;
  logic [FRAC_W-1:0]    signalling_estimate;
  logic [FRAC_W-1:0]    congestion_estimate;
  logic [TIME_W-1:0]    update_time;

  modport source (output valid, speed_limit, track_estimate, power_estimate,
                  signalling_estimate, congestion_estimate, update_time, input ready);
  modport sink (input valid, speed_limit, track_estimate, power_estimate,
                signalling_estimate, congestion_estimate, update_time, output ready);
endinterface

FILE: rtl/rck_cfg_if.sv
// Configuration write channel of the rail condition Kalman speed limit block.
// Carries a register index and write data; depends on rck_pkg.
interface rck_cfg_if;
  import rck_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/rck_div.sv
// Restoring divider that forms the Kalman gain one quotient bit per cycle.
// Expects dividend below divisor; depends on rck_pkg.
module rck_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rck_pkg::UNC_W-1:0]     dividend_i,
  input  logic [rck_pkg::UNC_W:0]       divisor_i,
  output logic                          done_o,
  output logic [rck_pkg::FRAC_BITS-1:0] quot_o
);
  import rck_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int REM_W = UNC_W + 2;

  logic [REM_W-1:0]     rem_q, rem_d, rem_sh;
  logic [UNC_W:0]       div_q;
  logic [FRAC_BITS-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;

  always_comb begin
    rem_sh = {rem_q[REM_W-2:0], 1'b0};
    if (rem_sh >= REM_W'(div_q)) begin
      rem_d  = rem_sh - REM_W'(div_q);
      quot_d = {quot_q[FRAC_BITS-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      quot_d = {quot_q[FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= REM_W'(dividend_i);
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/rck_mul.sv
// Shared registered multiplier that returns the product scaled down by the
// fraction width. Operands arrive as an rck_pkg::mul_op_t; depends on rck_pkg.
module rck_mul (
  input  logic                      clk_i,
  input  rck_pkg::mul_op_t          op_i,
  output logic [rck_pkg::RES_W-1:0] res_o
);
  import rck_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_i.a) * PROD_W'(op_i.b);
  end

  assign res_o = prod_q[PROD_W-1:FRAC_BITS];

endmodule

FILE: rtl/rail_condition_kalman_speed_limit_top.sv
// Rail condition monitor: four scalar Kalman estimates and a derived speed limit.
// Sequencer, state and configuration registers around rck_div and rck_mul.
//
// Usage: report items enter on report_i, one result item per report leaves
// on result_o, and cfg_i writes the six configuration registers (always
// ready). Write configuration only while no report is in flight.
// Each report adds process noise to all four uncertainties; a report that
// updates an estimate then updates the selected one through one gain
// division and two multiplies. Every report forms the speed limit through one
// friction multiply and four speed multiplies. All multiplies share one
// registered multiplier; the gain comes from a restoring divider that yields
// one bit per cycle of its 16-bit quotient. report_i.ready is low from
// acceptance until the sequencer returns to idle, one report at a time.
// The result sits in an output register; the next report is accepted while
// it waits. If the receiver stalls, the sequencer holds at its last step until
// the output register is free. Reset restores the register defaults, the
// estimates 1.0, 1.0, 1.0, 0.4, the uncertainties 0.5 and time zero.
module rail_condition_kalman_speed_limit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rck_in_if.sink     report_i,
  rck_out_if.source  result_o,
  rck_cfg_if.sink    cfg_i
);
  import rck_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_NOISE = 12'b000000000010,
    S_DIVGO = 12'b000000000100,
    S_DIVW  = 12'b000000001000,
    S_KX    = 12'b000000010000,
    S_KU    = 12'b000000100000,
    S_FRIC  = 12'b000001000000,
    S_SPT   = 12'b000010000000,
    S_SPS   = 12'b000100000000,
    S_SPP   = 12'b001000000000,
    S_SPF   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [NOISE_W-1:0] noise_q;
  logic [SPEED_W-1:0] dspeed_q;
  logic [FRAC_W-1:0]  thresh_q, sigfail_q, cap_q;
  logic [SLOPE_W-1:0] slope_q;

  logic [FRAC_W-1:0]  est_q [NUM_EST];
  logic [UNC_W-1:0]   unc_q [NUM_EST];
  logic [TIME_W-1:0]  time_q;

  logic [IDX_W-1:0]   idx_q;
  logic               upd_q;
  logic [FRAC_W-1:0]  z_q, r_q, k_q, fr_q;

  logic               out_valid_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [FRAC_W-1:0]  out_est_q [NUM_EST];
  logic [TIME_W-1:0]  out_time_q;

  logic               in_acc, out_load;
  logic [FRAC_W-1:0]  rel_c, sev_c, cval_c, est_sel, diff, tf, sf, pf, loss_fr;
  logic               z_ge, cong_over;
  logic [RES_W-1:0]   mul_res;
  mul_op_t            mul_op;
  logic               div_start, div_done;
  logic [FRAC_BITS-1:0] div_quot;
  logic [UNC_W:0]     div_den;

  assign report_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign in_acc         = report_i.valid && report_i.ready;
  assign out_load       = (state_q == S_DONE) && (!out_valid_q || result_o.ready);

  assign rel_c  = clamp_one(report_i.reliability);
  assign sev_c  = clamp_one(report_i.severity);
  assign cval_c = clamp_one(report_i.congestion_value);

  assign est_sel   = est_q[idx_q];
  assign z_ge      = (z_q >= est_sel);
  assign diff      = z_ge ? (z_q - est_sel) : (est_sel - z_q);
  assign cong_over = (est_q[EST_CONG] > cap_q);
  assign tf        = (est_q[EST_TRACK] < thresh_q) ? '0 : est_q[EST_TRACK];
  assign sf        = (est_q[EST_SIGNAL] < HALF) ? sigfail_q : ONE;
  assign pf        = (est_q[EST_POWER] > HALF) ? ONE : '0;
  assign loss_fr   = (mul_res > RES_W'(ONE - FRIC_FLOOR)) ? FRIC_FLOOR
                                                           : (ONE - mul_res[FRAC_W-1:0]);

  assign div_start = (state_q == S_DIVGO);
  assign div_den   = {1'b0, unc_q[idx_q]} + (UNC_W + 1)'(r_q);

  rck_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (unc_q[idx_q]),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rck_mul u_mul (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .res_o (mul_res)
  );

  always_comb begin
    mul_op = '0;
    case (state_q)
      S_KX: begin
        mul_op.a = MUL_A_W'(diff);
        mul_op.b = k_q;
      end
      S_KU: begin
        mul_op.a = unc_q[idx_q];
        mul_op.b = ONE - k_q;
      end
      S_FRIC: begin
        mul_op.a = slope_q;
        mul_op.b = est_q[EST_CONG] - cap_q;
      end
      S_SPT: begin
        mul_op.a = MUL_A_W'(dspeed_q);
        mul_op.b = tf;
      end
      S_SPS: begin
        mul_op.a = mul_res[MUL_A_W-1:0];
        mul_op.b = sf;
      end
      S_SPP: begin
        mul_op.a = mul_res[MUL_A_W-1:0];
        mul_op.b = pf;
      end
      S_SPF: begin
        mul_op.a = mul_res[MUL_A_W-1:0];
        mul_op.b = fr_q;
      end
      S_DONE: begin
        // The final speed circulates through the multiplier while the result waits.
        mul_op.a = mul_res[MUL_A_W-1:0];
        mul_op.b = ONE;
      end
      default: begin
        mul_op = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_NOISE;
      S_NOISE: state_d = upd_q ? S_DIVGO : S_FRIC;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (div_done) state_d = S_KX;
      S_KX:    state_d = S_KU;
      S_KU:    state_d = S_FRIC;
      S_FRIC:  state_d = S_SPT;
      S_SPT:   state_d = S_SPS;
      S_SPS:   state_d = S_SPP;
      S_SPP:   state_d = S_SPF;
      S_SPF:   state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      noise_q     <= RST_PROCESS_NOISE;
      dspeed_q    <= RST_DESIGN_SPEED;
      thresh_q    <= RST_DAMAGE_THRESH;
      sigfail_q   <= RST_SIG_FAIL;
      cap_q       <= RST_CONG_CAP;
      slope_q     <= RST_CONG_SLOPE;
      est_q[EST_TRACK]  <= ONE;
      est_q[EST_POWER]  <= ONE;
      est_q[EST_SIGNAL] <= ONE;
      est_q[EST_CONG]   <= RST_CONG_EST;
      for (int i = 0; i < NUM_EST; i++) begin
        unc_q[i] <= UNC_W'(HALF);
      end
      time_q <= '0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_PROCESS_NOISE: noise_q   <= cfg_i.data[NOISE_W-1:0];
          REG_DESIGN_SPEED:  dspeed_q  <= cfg_i.data[SPEED_W-1:0];
          REG_DAMAGE_THRESH: thresh_q  <= cfg_i.data[FRAC_W-1:0];
          REG_SIG_FAIL:      sigfail_q <= cfg_i.data[FRAC_W-1:0];
          REG_CONG_CAP:      cap_q     <= cfg_i.data[FRAC_W-1:0];
          REG_CONG_SLOPE:    slope_q   <= cfg_i.data[SLOPE_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        time_q <= report_i.report_time;
      end

      if (state_q == S_NOISE) begin
        for (int i = 0; i < NUM_EST; i++) begin
          if (({1'b0, unc_q[i]} + (UNC_W + 1)'(noise_q)) > (UNC_W + 1)'(UNC_MAX)) begin
            unc_q[i] <= UNC_MAX;
          end else begin
            unc_q[i] <= unc_q[i] + UNC_W'(noise_q);
          end
        end
      end

      if (state_q == S_KU) begin
        est_q[idx_q] <= z_ge ? (est_sel + mul_res[FRAC_W-1:0])
                             : (est_sel - mul_res[FRAC_W-1:0]);
      end

      if ((state_q == S_FRIC) && upd_q) begin
        unc_q[idx_q] <= mul_res[UNC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q <= ONE - rel_c + R_FLOOR;
      if (report_i.func == FUNC_CONG) begin
        idx_q <= EST_CONG;
        z_q   <= cval_c;
        upd_q <= report_i.value_present;
      end else begin
        idx_q <= IDX_W'(report_i.func - FUNC_TRACK);
        z_q   <= ONE - sev_c;
        upd_q <= (report_i.func inside {FUNC_TRACK, FUNC_POWER, FUNC_SIGNAL});
      end
    end
    if ((state_q == S_DIVW) && div_done) begin
      k_q <= {1'b0, div_quot};
    end
    if (state_q == S_SPT) begin
      fr_q <= cong_over ? loss_fr : ONE;
    end
    if (out_load) begin
      out_speed_q <= (mul_res > RES_W'(SPEED_MAX)) ? SPEED_MAX : mul_res[SPEED_W-1:0];
      for (int i = 0; i < NUM_EST; i++) begin
        out_est_q[i] <= est_q[i];
      end
      out_time_q <= time_q;
    end
  end

  assign result_o.valid               = out_valid_q;
  assign result_o.speed_limit         = out_speed_q;
  assign result_o.track_estimate      = out_est_q[EST_TRACK];
  assign result_o.power_estimate      = out_est_q[EST_POWER];
  assign result_o.signalling_estimate = out_est_q[EST_SIGNAL];
  assign result_o.congestion_estimate = out_est_q[EST_CONG];
  assign result_o.update_time         = out_time_q;

endmodule

FILE: rtl/rck_checker.sv
// Port-level checker for the rail condition Kalman speed limit block.
// Bound to the top level below; depends on rck_pkg.
module rck_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rck_pkg::SPEED_W-1:0] speed_limit_i,
  input logic [rck_pkg::FRAC_W-1:0]  track_estimate_i,
  input logic [rck_pkg::FRAC_W-1:0]  power_estimate_i,
  input logic [rck_pkg::FRAC_W-1:0]  signalling_estimate_i,
  input logic [rck_pkg::FRAC_W-1:0]  congestion_estimate_i,
  input logic [rck_pkg::TIME_W-1:0]  update_time_i
);
  import rck_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(speed_limit_i)
      && $stable(update_time_i) && $stable(track_estimate_i))
    else $error("Stalled result item changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Report channel ready right after an accepted item.");

  a_power_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (power_estimate_i <= HALF) |-> speed_limit_i == '0)
    else $error("Nonzero speed limit with power estimate at or below one half.");

  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (track_estimate_i <= ONE) && (power_estimate_i <= ONE)
      && (signalling_estimate_i <= ONE) && (congestion_estimate_i <= ONE))
    else $error("Estimate above one in a result item.");

endmodule

bind rail_condition_kalman_speed_limit_top rck_checker u_rck_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (report_i.valid),
  .in_ready_i            (report_i.ready),
  .out_valid_i           (result_o.valid),
  .out_ready_i           (result_o.ready),
  .speed_limit_i         (result_o.speed_limit),
  .track_estimate_i      (result_o.track_estimate),
  .power_estimate_i      (result_o.power_estimate),
  .signalling_estimate_i (result_o.signalling_estimate),
  .congestion_estimate_i (result_o.congestion_estimate),
  .update_time_i         (result_o.update_time)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rail condition Kalman speed limit block.
// Drives reports and register writes, predicts every result item and compares it.
// Depends on rck_pkg, the three channel interfaces and the block's top level.
module testbench;
  import rck_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 8;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int PRESSURE_PHASE  = 4;
  localparam int PRESSURE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int REG_COUNT       = 6;

  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_RSVD6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RSVD7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [REG_COUNT] = '{
    REG_PROCESS_NOISE, REG_DESIGN_SPEED, REG_DAMAGE_THRESH,
    REG_SIG_FAIL, REG_CONG_CAP, REG_CONG_SLOPE
  };

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [FRAC_W-1:0] reliability;
    logic [FRAC_W-1:0] severity;
    logic [FRAC_W-1:0] congestion_value;
    logic              value_present;
    logic [TIME_W-1:0] report_time;
  } condition_report_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_limit;
    logic [FRAC_W-1:0]  track_estimate;
    logic [FRAC_W-1:0]  power_estimate;
    logic [FRAC_W-1:0]  signalling_estimate;
    logic [FRAC_W-1:0]  congestion_estimate;
    logic [TIME_W-1:0]  update_time;
  } speed_result_t;

  typedef struct packed {
    condition_report_t rep;
    logic              typed;
    speed_result_t     want;
  } directed_row_t;

  logic clk;
  logic rst_n;

  rck_in_if  report_if ();
  rck_out_if result_if ();
  rck_cfg_if cfg_if ();

  rail_condition_kalman_speed_limit_top i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .report_i (report_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  logic [FRAC_W-1:0]  est_q [NUM_EST];
  logic [UNC_W-1:0]   unc_q [NUM_EST];
  logic [NOISE_W-1:0] noise_cfg;
  logic [SPEED_W-1:0] speed_cfg;
  logic [FRAC_W-1:0]  thresh_cfg;
  logic [FRAC_W-1:0]  sig_fail_cfg;
  logic [FRAC_W-1:0]  cap_cfg;
  logic [SLOPE_W-1:0] slope_cfg;

  speed_result_t pending_results [$];
  directed_row_t directed_rows [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_req   = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned reports_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned reg_writes     = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void kalman_correct(input logic [IDX_W-1:0] idx,
                                         input longint unsigned z, r);
    longint unsigned u, x, gain;
    u = unc_q[idx];
    x = est_q[idx];
    gain = (u << FRAC_BITS) / (u + r);
    if (gain > ONE) gain = ONE;
    if (z >= x) x = x + ((gain * (z - x)) >> FRAC_BITS);
    else x = x - ((gain * (x - z)) >> FRAC_BITS);
    est_q[idx] = FRAC_W'(x);
    unc_q[idx] = UNC_W'((u * (ONE - gain)) >> FRAC_BITS);
  endfunction

  function automatic speed_result_t apply_condition_report(input condition_report_t rep);
    longint unsigned rel, sev, cval, r, u;
    longint unsigned track, power, sig, cong, tf, sf, pf, fr, loss, s;
    speed_result_t res;
    rel  = (rep.reliability > ONE) ? ONE : rep.reliability;
    sev  = (rep.severity > ONE) ? ONE : rep.severity;
    cval = (rep.congestion_value > ONE) ? ONE : rep.congestion_value;
    r = ONE - rel + R_FLOOR;
    for (int i = 0; i < NUM_EST; i++) begin
      u = longint'(unc_q[i]) + noise_cfg;
      unc_q[i] = (u > UNC_MAX) ? UNC_MAX : UNC_W'(u);
    end
    case (rep.func)
      FUNC_TRACK:  kalman_correct(EST_TRACK, ONE - sev, r);
      FUNC_POWER:  kalman_correct(EST_POWER, ONE - sev, r);
      FUNC_SIGNAL: kalman_correct(EST_SIGNAL, ONE - sev, r);
      FUNC_CONG: begin
        if (rep.value_present) kalman_correct(EST_CONG, cval, r);
      end
      default: ;
    endcase
    track = est_q[EST_TRACK];
    power = est_q[EST_POWER];
    sig   = est_q[EST_SIGNAL];
    cong  = est_q[EST_CONG];
    tf = (track < thresh_cfg) ? 0 : track;
    sf = (sig < HALF) ? longint'(sig_fail_cfg) : longint'(ONE);
    pf = (power > HALF) ? longint'(ONE) : 0;
    fr = ONE;
    if (cong > cap_cfg) begin
      loss = ((cong - cap_cfg) * slope_cfg) >> FRAC_BITS;
      fr = (loss > ONE - FRIC_FLOOR) ? longint'(FRIC_FLOOR) : ONE - loss;
    end
    s = speed_cfg;
    s = (s * tf) >> FRAC_BITS;
    s = (s * sf) >> FRAC_BITS;
    s = (s * pf) >> FRAC_BITS;
    s = (s * fr) >> FRAC_BITS;
    if (s > SPEED_MAX) s = SPEED_MAX;
    res.speed_limit         = SPEED_W'(s);
    res.track_estimate      = est_q[EST_TRACK];
    res.power_estimate      = est_q[EST_POWER];
    res.signalling_estimate = est_q[EST_SIGNAL];
    res.congestion_estimate = est_q[EST_CONG];
    res.update_time         = rep.report_time;
    return res;
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction(input int unsigned p_zero, p_one);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < p_zero) return '0;
    if (roll < p_zero + p_one) return ONE;
    if (roll < p_zero + p_one + 5) return FRAC_W'($urandom_range(ONE_I + 1, 2 * ONE_I - 1));
    return FRAC_W'($urandom_range(0, ONE_I));
  endfunction

  function automatic void add_row(input logic [FUNC_W-1:0] func,
                                  input logic [FRAC_W-1:0] rel, sev, cval,
                                  input logic present, input logic [TIME_W-1:0] stamp,
                                  input logic typed = 1'b0,
                                  input logic [SPEED_W-1:0] speed = '0,
                                  input logic [FRAC_W-1:0] trk = '0, pwr = '0,
                                  input logic [FRAC_W-1:0] sgl = '0, cng = '0);
    directed_row_t row;
    row.rep  = '{func, rel, sev, cval, present, stamp};
    row.typed = typed;
    row.want = '{speed, trk, pwr, sgl, cng, stamp};
    directed_rows.push_back(row);
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_report(input condition_report_t rep, input logic typed,
                             input speed_result_t typed_result);
    speed_result_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      report_if.valid <= 1'b0;
      @(posedge clk);
    end
    report_if.valid            <= 1'b1;
    report_if.func             <= rep.func;
    report_if.reliability      <= rep.reliability;
    report_if.severity         <= rep.severity;
    report_if.congestion_value <= rep.congestion_value;
    report_if.value_present    <= rep.value_present;
    report_if.report_time      <= rep.report_time;
    @(posedge clk);
    while (!report_if.ready) @(posedge clk);
    predicted = apply_condition_report(rep);
    pending_results.push_back(typed ? typed_result : predicted);
    reports_sent++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_PROCESS_NOISE: noise_cfg    = data[NOISE_W-1:0];
      REG_DESIGN_SPEED:  speed_cfg    = data[SPEED_W-1:0];
      REG_DAMAGE_THRESH: thresh_cfg   = data[FRAC_W-1:0];
      REG_SIG_FAIL:      sig_fail_cfg = data[FRAC_W-1:0];
      REG_CONG_CAP:      cap_cfg      = data[FRAC_W-1:0];
      REG_CONG_SLOPE:    slope_cfg    = data[SLOPE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Result side: checks every accepted item and throttles ready.
  initial begin
    speed_result_t want;
    int unsigned   hold_left;
    bit            pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result item arrived with no report waiting");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("speed_limit", want.speed_limit, result_if.speed_limit);
          compare_field("track_estimate", want.track_estimate, result_if.track_estimate);
          compare_field("power_estimate", want.power_estimate, result_if.power_estimate);
          compare_field("signalling_estimate", want.signalling_estimate,
                        result_if.signalling_estimate);
          compare_field("congestion_estimate", want.congestion_estimate,
                        result_if.congestion_estimate);
          compare_field("update_time", want.update_time, result_if.update_time);
        end
      end
      if (pressure_req && !pressure_done) begin
        hold_left = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((report_if.valid && report_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    condition_report_t  rep;
    logic [CFG_DATA_W-1:0] cfg_vals [REG_COUNT];

    rst_n = 1'b0;
    report_if.valid = 1'b0;
    report_if.func = FUNC_NONE;
    report_if.reliability = '0;
    report_if.severity = '0;
    report_if.congestion_value = '0;
    report_if.value_present = 1'b0;
    report_if.report_time = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PROCESS_NOISE;
    cfg_if.data = '0;

    noise_cfg    = RST_PROCESS_NOISE;
    speed_cfg    = RST_DESIGN_SPEED;
    thresh_cfg   = RST_DAMAGE_THRESH;
    sig_fail_cfg = RST_SIG_FAIL;
    cap_cfg      = RST_CONG_CAP;
    slope_cfg    = RST_CONG_SLOPE;
    est_q = '{ONE, ONE, ONE, RST_CONG_EST};
    foreach (unc_q[i]) unc_q[i] = UNC_W'(HALF);

    // While no estimate has moved, every result is the reset picture.
    add_row(FUNC_NONE, '0, '0, '0, 1'b0, '0, 1'b1, RST_DESIGN_SPEED, ONE, ONE, ONE,
            RST_CONG_EST);
    add_row(FUNC_RSVD7, ONE, ONE, ONE, 1'b1, TIME_MAX, 1'b1, RST_DESIGN_SPEED, ONE, ONE, ONE,
            RST_CONG_EST);
    add_row(FUNC_TRACK, ONE, '0, '0, 1'b0, 63'd1, 1'b1, RST_DESIGN_SPEED, ONE, ONE, ONE,
            RST_CONG_EST);
    add_row(FUNC_POWER, 17'h1FFFF, '0, 17'h1FFFF, 1'b1, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1,
            RST_DESIGN_SPEED, ONE, ONE, ONE, RST_CONG_EST);
    add_row(FUNC_SIGNAL, '0, '0, '0, 1'b0, 63'h5555_5555_5555_5555, 1'b1, RST_DESIGN_SPEED,
            ONE, ONE, ONE, RST_CONG_EST);
    add_row(FUNC_CONG, ONE, '0, ONE, 1'b0, 63'd7, 1'b1, RST_DESIGN_SPEED, ONE, ONE, ONE,
            RST_CONG_EST);
    add_row(FUNC_RSVD5, 17'h0FFFF, 17'h1FFFF, '0, 1'b1, 63'd8, 1'b1, RST_DESIGN_SPEED,
            ONE, ONE, ONE, RST_CONG_EST);
    add_row(FUNC_RSVD6, '0, ONE, ONE, 1'b0, 63'd9, 1'b1, RST_DESIGN_SPEED, ONE, ONE, ONE,
            RST_CONG_EST);
    add_row(FUNC_CONG, ONE, '0, RST_CONG_EST, 1'b1, 63'd10, 1'b1, RST_DESIGN_SPEED,
            ONE, ONE, ONE, RST_CONG_EST);
    add_row(FUNC_TRACK, ONE, ONE, '0, 1'b0, 63'd11);
    add_row(FUNC_TRACK, ONE, '0, '0, 1'b0, 63'd12);
    add_row(FUNC_TRACK, ONE, '0, '0, 1'b0, 63'd13);
    add_row(FUNC_POWER, ONE, ONE, '0, 1'b0, 63'd14);
    add_row(FUNC_POWER, ONE, '0, '0, 1'b0, 63'd15);
    add_row(FUNC_POWER, ONE, '0, '0, 1'b0, 63'd16);
    add_row(FUNC_SIGNAL, ONE, 17'h1FFFF, '0, 1'b0, 63'd17);
    add_row(FUNC_SIGNAL, '0, '0, '0, 1'b0, 63'd18);
    add_row(FUNC_SIGNAL, ONE, '0, '0, 1'b0, 63'd19);
    add_row(FUNC_CONG, ONE, '0, 17'h1FFFF, 1'b1, 63'd20);
    add_row(FUNC_CONG, 17'h08000, '0, 17'h0C000, 1'b1, 63'd21);
    add_row(FUNC_CONG, ONE, '0, '0, 1'b1, 63'd22);
    add_row(FUNC_TRACK, 17'h08000, 17'h04000, '0, 1'b0, 63'd23);
    add_row(FUNC_NONE, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, TIME_MAX);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_report(directed_rows[i].rep, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        case (phase)
          1: cfg_vals = '{default: '0};
          2: cfg_vals = '{20'h0FFFF, 20'h0FFFF, 20'h0, 20'h1FFFF, CFG_DATA_W'(ONE), 20'hFFFFF};
          3: cfg_vals = '{20'h1, 20'h06400, CFG_DATA_W'(ONE), CFG_DATA_W'(ONE), 20'h0,
                          20'hFFFFF};
          6: cfg_vals = '{default: 20'hFFFFF};
          7: cfg_vals = '{CFG_DATA_W'(RST_PROCESS_NOISE), CFG_DATA_W'(RST_DESIGN_SPEED),
                          CFG_DATA_W'(RST_DAMAGE_THRESH), CFG_DATA_W'(RST_SIG_FAIL),
                          CFG_DATA_W'(RST_CONG_CAP), CFG_DATA_W'(RST_CONG_SLOPE)};
          default: foreach (cfg_vals[i]) cfg_vals[i] = CFG_DATA_W'($urandom);
        endcase
        foreach (REG_ORDER[i]) write_register(REG_ORDER[i], cfg_vals[i]);
        if (phase == 4 || phase == 5) begin
          write_register(REG_RSVD6, CFG_DATA_W'($urandom));
          write_register(REG_RSVD7, CFG_DATA_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
      end

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (phase == PRESSURE_PHASE) pressure_req = 1'b1;

      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) rep.func = FUNC_W'($urandom_range(FUNC_TRACK, FUNC_CONG));
        else rep.func = FUNC_W'($urandom);
        rep.reliability      = pick_fraction(5, 25);
        rep.severity         = pick_fraction(30, 20);
        rep.congestion_value = pick_fraction(20, 25);
        rep.value_present    = ($urandom_range(99) < 80);
        rep.report_time      = ($urandom_range(99) < 5) ? '0 : TIME_W'({$urandom, $urandom});
        send_report(rep, 1'b0, '0);
      end
      report_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d reports and %0d checked results across %0d register settings,",
             reports_sent, results_seen, NUM_PHASES);
    $display("with %0d register writes, sender gaps, receiver stalls and one long hold-off.",
             reg_writes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rck_pkg.sv
rtl/rck_in_if.sv
rtl/rck_out_if.sv
rtl/rck_cfg_if.sv
rtl/rck_div.sv
rtl/rck_mul.sv
rtl/rail_condition_kalman_speed_limit_top.sv
rtl/rck_checker.sv
sim/testbench.sv
